// File: hdl/olt_pkg.sv
// ----------------------------------------------------------------------------
// olt_pkg: shared types and constants of the ordered list table
// Operation and status codes, controller states and the command and status
// words between the controller and the datapath.
// ----------------------------------------------------------------------------
package olt_pkg;

    localparam int OLT_CAPACITY  = 64;
    localparam int OLT_ITEM_BITS = 32;
    localparam int POS_BITS      = 6;
    localparam int VALUE_BITS    = 32;
    localparam int LENGTH_BITS   = 7;

    typedef enum logic [2:0] {
        FN_GET    = 3'd0,
        FN_SET    = 3'd1,
        FN_INSERT = 3'd2,
        FN_REMOVE = 3'd3,
        FN_SEARCH = 3'd4,
        FN_CLEAR  = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [9:0] {
        S_INIT = 10'b00_0000_0001,
        S_IDLE = 10'b00_0000_0010,
        S_EXEC = 10'b00_0000_0100,
        S_GET  = 10'b00_0000_1000,
        S_URD  = 10'b00_0001_0000,
        S_UWR  = 10'b00_0010_0000,
        S_DRD  = 10'b00_0100_0000,
        S_DWR  = 10'b00_1000_0000,
        S_SRD  = 10'b01_0000_0000,
        S_SCMP = 10'b10_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        RS_POS,
        RS_PTR,
        RS_PTR_DN,
        RS_PTR_UP
    } t_rsel;

    typedef enum logic [1:0] {
        WS_VAL_POS,
        WS_RD_PTR,
        WS_ZERO_PTR
    } t_wsel;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_CNT,
        PTR_POS,
        PTR_INC,
        PTR_DEC
    } t_ptr_op;

    typedef enum logic [2:0] {
        CNT_HOLD,
        CNT_ZERO,
        CNT_INC,
        CNT_DEC,
        CNT_AT_POS
    } t_cnt_op;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        t_rsel   rd_sel;
        logic    wr_en;
        t_wsel   wr_sel;
        t_ptr_op ptr_op;
        t_cnt_op cnt_op;
        logic    fin;
        t_status fin_status;
        logic    fin_read;
        logic    fin_found;
    } t_cmd;

    typedef struct packed {
        logic [2:0] func;
        logic       pos_ok;
        logic       pos_lt_len;
        logic       full;
        logic       ptr_eq_pos;
        logic       ptr_ge_len;
        logic       ptr_last;
        logic       match;
    } t_stat;

endpackage

// File: hdl/olt_ctrl.sv
// ----------------------------------------------------------------------------
// olt_ctrl: operation sequencer of the ordered list table
// Walks the clearing sweep after reset, then decodes each word and steps
// the datapath through reads, shifts and searches.
// ----------------------------------------------------------------------------
module olt_ctrl
    import olt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.rd_sel     = RS_POS;
        o_cmd.wr_sel     = WS_VAL_POS;
        o_cmd.ptr_op     = PTR_HOLD;
        o_cmd.cnt_op     = CNT_HOLD;
        o_cmd.fin_status = ST_OK;
        unique case (r_state)
            S_INIT: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_ZERO_PTR;
                if (i_stat.ptr_last) begin
                    o_cmd.ptr_op = PTR_ZERO;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.ptr_op = PTR_INC;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state   = S_IDLE;
                o_cmd.fin = 1'b1;
                unique case (i_stat.func)
                    FN_GET: begin
                        if (i_stat.pos_ok) begin
                            o_cmd.fin   = 1'b0;
                            o_cmd.rd_en = 1'b1;
                            n_state     = S_GET;
                        end else begin
                            o_cmd.fin_status = ST_RANGE;
                        end
                    end
                    FN_SET: begin
                        if (i_stat.pos_ok) begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.cnt_op = CNT_AT_POS;
                        end else begin
                            o_cmd.fin_status = ST_RANGE;
                        end
                    end
                    FN_INSERT: begin
                        if (!i_stat.pos_lt_len) begin
                            if (i_stat.pos_ok) begin
                                o_cmd.wr_en  = 1'b1;
                                o_cmd.cnt_op = CNT_AT_POS;
                            end else begin
                                o_cmd.fin_status = ST_RANGE;
                            end
                        end else if (i_stat.full) begin
                            o_cmd.fin_status = ST_FULL;
                        end else begin
                            o_cmd.fin    = 1'b0;
                            o_cmd.ptr_op = PTR_CNT;
                            n_state      = S_URD;
                        end
                    end
                    FN_REMOVE: begin
                        if (!i_stat.pos_lt_len) begin
                            o_cmd.fin_status = ST_RANGE;
                        end else begin
                            o_cmd.fin    = 1'b0;
                            o_cmd.cnt_op = CNT_DEC;
                            o_cmd.ptr_op = PTR_POS;
                            n_state      = S_DRD;
                        end
                    end
                    FN_SEARCH: begin
                        o_cmd.fin    = 1'b0;
                        o_cmd.ptr_op = PTR_ZERO;
                        n_state      = S_SRD;
                    end
                    FN_CLEAR: begin
                        o_cmd.cnt_op = CNT_ZERO;
                    end
                    default: begin
                        o_cmd.fin_status = ST_OK;
                    end
                endcase
            end
            S_GET: begin
                o_cmd.fin      = 1'b1;
                o_cmd.fin_read = 1'b1;
                n_state        = S_IDLE;
            end
            S_URD: begin
                if (i_stat.ptr_eq_pos) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.cnt_op = CNT_INC;
                    o_cmd.fin    = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RS_PTR_DN;
                    n_state      = S_UWR;
                end
            end
            S_UWR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_RD_PTR;
                o_cmd.ptr_op = PTR_DEC;
                n_state      = S_URD;
            end
            S_DRD: begin
                if (i_stat.ptr_ge_len) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RS_PTR_UP;
                    n_state      = S_DWR;
                end
            end
            S_DWR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_RD_PTR;
                o_cmd.ptr_op = PTR_INC;
                n_state      = S_DRD;
            end
            S_SRD: begin
                if (i_stat.ptr_ge_len) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RS_PTR;
                    n_state      = S_SCMP;
                end
            end
            S_SCMP: begin
                if (i_stat.match) begin
                    o_cmd.fin       = 1'b1;
                    o_cmd.fin_found = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.ptr_op = PTR_INC;
                    n_state      = S_SRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/olt_dp.sv
// ----------------------------------------------------------------------------
// olt_dp: datapath of the ordered list table
// Entry memory with one write and one registered read port, length counter,
// walking pointer, operand registers and result registers.
// ----------------------------------------------------------------------------
module olt_dp
    import olt_pkg::*;
#(
    parameter int CAPACITY  = OLT_CAPACITY,
    parameter int ITEM_BITS = OLT_ITEM_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic [2:0]             i_func,
    input  logic [POS_BITS-1:0]    i_position,
    input  logic [VALUE_BITS-1:0]  i_item_value,
    output t_stat                  o_stat,
    output logic                   o_valid,
    output logic [1:0]             o_status,
    output logic [VALUE_BITS-1:0]  o_read_value,
    output logic                   o_found,
    output logic [POS_BITS-1:0]    o_found_position,
    output logic [LENGTH_BITS-1:0] o_length,
    output logic                   o_list_empty
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CMP_W  = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;

    logic [ITEM_BITS-1:0] r_mem [CAPACITY];

    logic [2:0]             r_func;
    logic [POS_BITS-1:0]    r_pos;
    logic [ITEM_BITS-1:0]   r_key;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic [CNT_W-1:0]       r_ptr;
    logic [CNT_W-1:0]       n_ptr;
    logic [ITEM_BITS-1:0]   r_rdata;
    logic                   r_valid;
    t_status                r_status;
    logic [VALUE_BITS-1:0]  r_read;
    logic                   r_found;
    logic [POS_BITS-1:0]    r_fpos;

    logic [63:0]            w_val_ext;
    logic [63:0]            w_rd_ext;
    logic [CMP_W-1:0]       w_pos_x;
    logic [CMP_W-1:0]       w_cnt_x;
    logic [CMP_W-1:0]       w_ptr_x;
    logic [CNT_W-1:0]       w_ptr_dn;
    logic [CNT_W-1:0]       w_ptr_up;
    logic [ADDR_W-1:0]      w_pos_addr;
    logic [ADDR_W-1:0]      w_raddr;
    logic [ADDR_W-1:0]      w_waddr;
    logic [ITEM_BITS-1:0]   w_wdata;
    logic [LENGTH_BITS+CNT_W-1:0] w_len_ext;

    assign w_val_ext  = 64'(i_item_value);
    assign w_rd_ext   = 64'(r_rdata);
    assign w_pos_x    = CMP_W'(r_pos);
    assign w_cnt_x    = CMP_W'(r_count);
    assign w_ptr_x    = CMP_W'(r_ptr);
    assign w_ptr_dn   = r_ptr - CNT_W'(1);
    assign w_ptr_up   = r_ptr + CNT_W'(1);
    assign w_pos_addr = w_pos_x[ADDR_W-1:0];

    assign o_stat.func       = r_func;
    assign o_stat.pos_ok     = (w_pos_x < CMP_W'(CAPACITY));
    assign o_stat.pos_lt_len = (w_pos_x < w_cnt_x);
    assign o_stat.full       = (r_count >= CNT_W'(CAPACITY));
    assign o_stat.ptr_eq_pos = (w_ptr_x == w_pos_x);
    assign o_stat.ptr_ge_len = (r_ptr >= r_count);
    assign o_stat.ptr_last   = (r_ptr == CNT_W'(CAPACITY - 1));
    assign o_stat.match      = (r_rdata == r_key);

    always_comb begin
        unique case (i_cmd.rd_sel)
            RS_POS:    w_raddr = w_pos_addr;
            RS_PTR:    w_raddr = r_ptr[ADDR_W-1:0];
            RS_PTR_DN: w_raddr = w_ptr_dn[ADDR_W-1:0];
            RS_PTR_UP: w_raddr = w_ptr_up[ADDR_W-1:0];
            default:   w_raddr = r_ptr[ADDR_W-1:0];
        endcase
    end

    always_comb begin
        unique case (i_cmd.wr_sel)
            WS_VAL_POS: begin
                w_waddr = w_pos_addr;
                w_wdata = r_key;
            end
            WS_RD_PTR: begin
                w_waddr = r_ptr[ADDR_W-1:0];
                w_wdata = r_rdata;
            end
            default: begin
                w_waddr = r_ptr[ADDR_W-1:0];
                w_wdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_comb begin
        unique case (i_cmd.ptr_op)
            PTR_ZERO: n_ptr = '0;
            PTR_CNT:  n_ptr = r_count;
            PTR_POS:  n_ptr = w_pos_x[CNT_W-1:0];
            PTR_INC:  n_ptr = w_ptr_up;
            PTR_DEC:  n_ptr = w_ptr_dn;
            default:  n_ptr = r_ptr;
        endcase
    end

    always_comb begin
        unique case (i_cmd.cnt_op)
            CNT_ZERO:   n_count = '0;
            CNT_INC:    n_count = r_count + CNT_W'(1);
            CNT_DEC:    n_count = r_count - CNT_W'(1);
            CNT_AT_POS: n_count = (w_pos_x == w_cnt_x) ? r_count + CNT_W'(1) : r_count;
            default:    n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ptr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ptr   <= n_ptr;
            r_valid <= i_cmd.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_pos  <= i_position;
            r_key  <= w_val_ext[ITEM_BITS-1:0];
        end
        if (i_cmd.fin) begin
            r_status <= i_cmd.fin_status;
            r_read   <= i_cmd.fin_read ? w_rd_ext[VALUE_BITS-1:0] : '0;
            r_found  <= i_cmd.fin_found;
            r_fpos   <= i_cmd.fin_found ? w_ptr_x[POS_BITS-1:0] : '0;
        end
    end

    assign w_len_ext        = (LENGTH_BITS + CNT_W)'(r_count);
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_read_value     = r_read;
    assign o_found          = r_found;
    assign o_found_position = r_fpos;
    assign o_length         = w_len_ext[LENGTH_BITS-1:0];
    assign o_list_empty     = (r_count == '0);

endmodule

// File: hdl/ordered_list_table.sv
// ----------------------------------------------------------------------------
// ordered_list_table: fixed-capacity ordered list with get, set, insert,
// remove, search and clear, one word at a time.
// Steps: get reads the entry at the position; insert shifts the entries from the
//   tail up to the position, remove shifts those after it down, and search reads
//   from the front, all through the single read port of the entry memory.
// Throughput: one word at a time; busy stays high until the result strobe.
// Reset: synchronous; a clearing sweep zeroes the entries
//   with busy high. Results strobe for one cycle and are never stalled.
// ----------------------------------------------------------------------------
module ordered_list_table
    import olt_pkg::*;
#(
    parameter int CAPACITY  = OLT_CAPACITY,
    parameter int ITEM_BITS = OLT_ITEM_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [2:0]             i_func,
    input  logic [POS_BITS-1:0]    i_position,
    input  logic [VALUE_BITS-1:0]  i_item_value,
    output logic                   o_valid,
    output logic [1:0]             o_status,
    output logic [VALUE_BITS-1:0]  o_read_value,
    output logic                   o_found,
    output logic [POS_BITS-1:0]    o_found_position,
    output logic [LENGTH_BITS-1:0] o_length,
    output logic                   o_list_empty
);

    t_cmd  w_cmd;
    t_stat w_stat;

    olt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    olt_dp #(
        .CAPACITY  (CAPACITY),
        .ITEM_BITS (ITEM_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_func           (i_func),
        .i_position       (i_position),
        .i_item_value     (i_item_value),
        .o_stat           (w_stat),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_read_value     (o_read_value),
        .o_found          (o_found),
        .o_found_position (o_found_position),
        .o_length         (o_length),
        .o_list_empty     (o_list_empty)
    );

endmodule

// File: hdl/olt_checker.sv
// ----------------------------------------------------------------------------
// olt_checker: port-level checks of the ordered list table
// Strobe spacing, busy behavior and consistency of the result fields.
// ----------------------------------------------------------------------------
module olt_checker
    import olt_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_valid,
    input logic [1:0]            o_status,
    input logic [VALUE_BITS-1:0] o_read_value,
    input logic                  o_found
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted word");

    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> (o_status == ST_OK) && (o_read_value == '0))
        else $error("search hit with bad status or read data");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> !o_found && (o_read_value == '0))
        else $error("failed operation carries data");

endmodule

bind ordered_list_table olt_checker u_olt_checker (.*);
